### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/apsc_pkg.sv
// ----------------------------------------------------------------------------
// apsc_pkg
// Widths, register indexes and sequencer states of the step counter.
// ----------------------------------------------------------------------------
package apsc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 24;
    localparam int THR_W       = 16;
    localparam int GAP_W       = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int SUM_W       = 2 * SAMPLE_BITS;
    localparam int REM_W       = SAMPLE_BITS + 2;
    localparam int ITER_W      = $clog2(SAMPLE_BITS + 1);
    localparam int CMP_W       = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 1;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(147);
    localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(2);

    localparam logic [CFG_IDX_W-1:0] REG_PEAK_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP        = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_UPDATE
    } t_state;

endpackage

### rtl/apsc_isqrt.sv
// ----------------------------------------------------------------------------
// apsc_isqrt
// Floor square root, one result bit per cycle with a restoring step.
// ----------------------------------------------------------------------------
module apsc_isqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [apsc_pkg::SUM_W-1:0]      i_radicand,
    output logic                            o_done,
    output logic [apsc_pkg::SAMPLE_BITS-1:0] o_root
);
    import apsc_pkg::*;

    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic [ITER_W-1:0]       r_iter, n_iter;
    logic [SUM_W-1:0]        r_rad, n_rad;
    logic [REM_W-1:0]        r_rem, n_rem;
    logic [SAMPLE_BITS-1:0]  r_root, n_root;
    logic [REM_W+1:0]        w_shift;
    logic [REM_W+1:0]        w_trial;

    always_comb begin
        w_shift = {r_rem, r_rad[SUM_W-1 -: 2]};
        w_trial = (REM_W+2)'({r_root, 2'b01});
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_iter  = r_iter;
        n_rad   = r_rad;
        n_rem   = r_rem;
        n_root  = r_root;
        if (i_start) begin
            n_busy = 1'b1;
            n_iter = ITER_W'(SAMPLE_BITS);
            n_rad  = i_radicand;
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            n_rad  = {r_rad[SUM_W-3:0], 2'b00};
            n_iter = r_iter - ITER_W'(1);
            if (w_shift >= w_trial) begin
                n_rem  = REM_W'(w_shift - w_trial);
                n_root = {r_root[SAMPLE_BITS-2:0], 1'b1};
            end else begin
                n_rem  = REM_W'(w_shift);
                n_root = {r_root[SAMPLE_BITS-2:0], 1'b0};
            end
            if (r_iter == ITER_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_iter <= n_iter;
        end
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

### rtl/accel_peak_step_counter_unit.sv
// ----------------------------------------------------------------------------
// accel_peak_step_counter_unit
// Accelerometer magnitude and peak-based step counter.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one x, y, z sample and a restart flag.
// A request is taken when i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall carry step count, step event, peak flag
// and magnitude; a result is taken when o_valid is high and i_stall is low.
// Configuration: i_cfg_valid / o_cfg_ready write peak_threshold (index 0) or
// min_gap (index 1); other indexes are ignored. Write only while idle.
// Flow: x, y and z are squared through one shared 16x16 multiplier into an
// accumulator, then go through the one-bit-per-cycle square root unit, then
// the window update. One request is worked at a time and the next is taken
// in the idle state after the update.
// A finished result sits in the output register; a new request is taken
// meanwhile, and its update waits while the previous result is stalled.
// Reset restores the register defaults and clears window and step count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module accel_peak_step_counter_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [apsc_pkg::SAMPLE_BITS-1:0] i_accel_x,
    input  logic signed [apsc_pkg::SAMPLE_BITS-1:0] i_accel_y,
    input  logic signed [apsc_pkg::SAMPLE_BITS-1:0] i_accel_z,
    input  logic                                  i_restart,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [apsc_pkg::COUNT_BITS-1:0]       o_step_count,
    output logic                                  o_step_event,
    output logic                                  o_peak_seen,
    output logic [apsc_pkg::SAMPLE_BITS-1:0]      o_magnitude,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [apsc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [apsc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import apsc_pkg::*;

    localparam logic [COUNT_BITS-1:0] STEP_MAX = '1;
    localparam logic [GAP_W-1:0]      GAP_MAX  = '1;

    t_state                         r_state, n_state;
    logic [1:0]                     r_cnt, n_cnt;
    logic signed [SAMPLE_BITS-1:0]  r_ax, r_ay, r_az;
    logic                           r_restart;
    logic signed [SAMPLE_BITS-1:0]  w_op;
    logic signed [SUM_W-1:0]        w_sq;
    logic [SUM_W-1:0]               r_prod, n_prod;
    logic [SUM_W-1:0]               r_acc, n_acc;
    logic                           w_accept;
    logic                           w_root_start;
    logic                           w_root_done;
    logic [SAMPLE_BITS-1:0]         w_root;

    logic [THR_W-1:0]               r_thr;
    logic [GAP_W-1:0]               r_gap;

    logic [SAMPLE_BITS-1:0]         r_early, r_mid, r_late;
    logic [1:0]                     r_seen;
    logic                           r_have;
    logic [GAP_W-1:0]               r_since;
    logic [COUNT_BITS-1:0]          r_steps;
    logic [SAMPLE_BITS-1:0]         n_early, n_mid, n_late;
    logic [1:0]                     n_seen;
    logic                           n_have;
    logic [GAP_W-1:0]               n_since;
    logic [COUNT_BITS-1:0]          n_steps;
    logic                           n_peak, n_event;

    logic [SAMPLE_BITS-1:0]         w_early, w_mid, w_late;
    logic [1:0]                     w_seen;
    logic                           w_have;
    logic [GAP_W-1:0]               w_since;
    logic [COUNT_BITS-1:0]          w_steps;
    logic [CMP_W-1:0]               w_lim_e, w_lim_l;
    logic                           w_out_free;
    logic                           w_update;

    logic                           r_out_valid;
    logic [COUNT_BITS-1:0]          r_out_count;
    logic                           r_out_event;
    logic                           r_out_peak;
    logic [SAMPLE_BITS-1:0]         r_out_mag;

    assign w_accept     = i_valid && !o_stall;
    assign w_out_free   = !r_out_valid || !i_stall;
    assign w_root_start = (r_state == ST_SQUARE) && (r_cnt == 2'd3);
    assign w_update     = (r_state == ST_UPDATE) && w_out_free;

    apsc_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_root_start),
        .i_radicand (n_acc),
        .o_done     (w_root_done),
        .o_root     (w_root)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (w_accept) begin
                    n_state = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    n_state = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (w_root_done) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // shared squarer and accumulator
    always_comb begin
        case (r_cnt)
            2'd0:    w_op = r_ax;
            2'd1:    w_op = r_ay;
            default: w_op = r_az;
        endcase
        w_sq   = w_op * w_op;
        n_prod = unsigned'(w_sq);
        n_acc  = r_acc;
        if (r_state == ST_SQUARE && r_cnt != 2'd0) begin
            n_acc = r_acc + r_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ax      <= i_accel_x;
            r_ay      <= i_accel_y;
            r_az      <= i_accel_z;
            r_restart <= i_restart;
            r_acc     <= '0;
        end else begin
            r_acc     <= n_acc;
        end
        r_prod <= n_prod;
    end

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
            r_gap <= GAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_PEAK_THRESHOLD: r_thr <= THR_W'(i_cfg_data);
                REG_MIN_GAP:        r_gap <= GAP_W'(i_cfg_data);
                default:            ;
            endcase
        end
    end

    // window and step update
    always_comb begin
        w_early = r_restart ? '0 : r_early;
        w_mid   = r_restart ? '0 : r_mid;
        w_late  = r_restart ? '0 : r_late;
        w_seen  = r_restart ? '0 : r_seen;
        w_have  = r_restart ? 1'b0 : r_have;
        w_since = r_restart ? '0 : r_since;
        w_steps = r_restart ? '0 : r_steps;
        w_lim_e = CMP_W'(w_early) + CMP_W'(r_thr);
        w_lim_l = CMP_W'(w_late) + CMP_W'(r_thr);
        n_early = w_early;
        n_mid   = w_mid;
        n_late  = w_late;
        n_seen  = w_seen;
        n_have  = w_have;
        n_since = w_since;
        n_steps = w_steps;
        n_peak  = 1'b0;
        n_event = 1'b0;
        case (w_seen)
            2'd0: begin
                n_early = '0;
                n_mid   = w_root;
                n_seen  = 2'd1;
            end
            2'd1: begin
                n_late = w_root;
                n_seen = 2'd2;
            end
            default: begin
                if (CMP_W'(w_mid) > w_lim_e && CMP_W'(w_mid) > w_lim_l) begin
                    n_peak = 1'b1;
                    if (w_have && w_since > r_gap && w_steps != STEP_MAX) begin
                        n_steps = w_steps + COUNT_BITS'(1);
                        n_event = 1'b1;
                    end
                    n_have  = 1'b1;
                    n_since = '0;
                end else if (w_have && w_since != GAP_MAX) begin
                    n_since = w_since + GAP_W'(1);
                end
                n_early = w_mid;
                n_mid   = w_late;
                n_late  = w_root;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_early <= '0;
            r_mid   <= '0;
            r_late  <= '0;
            r_seen  <= '0;
            r_have  <= 1'b0;
            r_since <= '0;
            r_steps <= '0;
        end else if (w_update) begin
            r_early <= n_early;
            r_mid   <= n_mid;
            r_late  <= n_late;
            r_seen  <= n_seen;
            r_have  <= n_have;
            r_since <= n_since;
            r_steps <= n_steps;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_update) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_update) begin
            r_out_count <= n_steps;
            r_out_event <= n_event;
            r_out_peak  <= n_peak;
            r_out_mag   <= w_root;
        end
    end

    assign o_stall      = (r_state != ST_IDLE);
    assign o_valid      = r_out_valid;
    assign o_step_count = r_out_count;
    assign o_step_event = r_out_event;
    assign o_peak_seen  = r_out_peak;
    assign o_magnitude  = r_out_mag;

    `ASSERT_IMPLY(a_event_has_peak, i_clk, i_rst_n, o_valid && o_step_event, o_peak_seen, "step event without peak")
    `ASSERT_IMPLY(a_event_count_nz, i_clk, i_rst_n, o_valid && o_step_event, o_step_count != '0, "step event with zero count")
    `ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, w_accept, r_state == ST_SQUARE && r_cnt == 2'd0, "request did not start squaring")
    `ASSERT_IMPLY(a_done_in_root, i_clk, i_rst_n, w_root_done, r_state == ST_ROOT, "root done outside root phase")

endmodule
